FILE: rtl/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types and constants of the packed bitmap span-fill engine.
// ----------------------------------------------------------------------------
package bsfe_pkg;

    // Packed word geometry
    localparam int WORD_BITS = 64;
    localparam int OFF_W     = 6;                 // bit offset within a word
    localparam int COL_W     = 13;                // column, width and height
    localparam int POS_W     = 28;                // linear bit position
    localparam int WIDX_W    = POS_W - OFF_W;     // word index from a position

    // Item field widths
    localparam int MODE_W = 2;
    localparam int COORD_W = 16;
    localparam int RIDX_W = 12;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic [COL_W-1:0] WIDTH_RST  = 13'd512;
    localparam logic [COL_W-1:0] HEIGHT_RST = 13'd512;

    // Item operations
    typedef enum logic [MODE_W-1:0] {
        MODE_SET  = 2'd0,
        MODE_CLR  = 2'd1,
        MODE_READ = 2'd2,
        MODE_WIPE = 2'd3
    } t_mode;

    // Word range and edge masks of one span
    typedef struct packed {
        logic                 ok;
        logic [WIDX_W-1:0]    sw;
        logic [WIDX_W-1:0]    ew;
        logic [WORD_BITS-1:0] lo_mask;
        logic [WORD_BITS-1:0] hi_mask;
    } t_span_plan;

endpackage

FILE: rtl/bsfe_in_if.sv
// ----------------------------------------------------------------------------
// bsfe_in_if
// Item channel of the span-fill engine: valid/ready plus the item payload.
// ----------------------------------------------------------------------------
interface bsfe_in_if;
    logic                                valid;
    logic                                ready;
    logic [bsfe_pkg::MODE_W-1:0]         mode;
    logic signed [bsfe_pkg::COORD_W-1:0] row;
    logic signed [bsfe_pkg::COORD_W-1:0] x_start;
    logic signed [bsfe_pkg::COORD_W-1:0] x_end;
    logic [bsfe_pkg::RIDX_W-1:0]         word_index;

    modport source (output valid, mode, row, x_start, x_end, word_index, input ready);
    modport sink   (input valid, mode, row, x_start, x_end, word_index, output ready);
endinterface

FILE: rtl/bsfe_out_if.sv
// ----------------------------------------------------------------------------
// bsfe_out_if
// Result channel of the span-fill engine: valid/ready plus the result payload.
// ----------------------------------------------------------------------------
interface bsfe_out_if;
    logic                               valid;
    logic                               ready;
    logic [bsfe_pkg::WORD_BITS-1:0]     read_data;
    logic                               span_applied;

    modport source (output valid, read_data, span_applied, input ready);
    modport sink   (input valid, read_data, span_applied, output ready);
endinterface

FILE: rtl/bsfe_span_calc.sv
// ----------------------------------------------------------------------------
// bsfe_span_calc
// Two-stage span planner: clamps the columns, checks the row, forms the
// row base with one multiplier, then derives word range and edge masks.
// ----------------------------------------------------------------------------
module bsfe_span_calc #(
    parameter int MASK_WORDS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [bsfe_pkg::COORD_W-1:0] i_row,
    input  logic signed [bsfe_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [bsfe_pkg::COORD_W-1:0] i_x_end,
    input  logic [bsfe_pkg::COL_W-1:0]          i_width,
    input  logic [bsfe_pkg::COL_W-1:0]          i_height,
    output logic                                o_done,
    output bsfe_pkg::t_span_plan                o_plan
);

    localparam int POS_W = bsfe_pkg::POS_W;
    localparam int OFF_W = bsfe_pkg::OFF_W;
    localparam int COL_W = bsfe_pkg::COL_W;
    localparam int WB    = bsfe_pkg::WORD_BITS;
    localparam logic [POS_W-1:0] CAP = POS_W'(MASK_WORDS * WB);

    // Clamp a signed column to 0..width
    function automatic logic [COL_W-1:0] clamp_col(
        input logic signed [bsfe_pkg::COORD_W-1:0] v,
        input logic [COL_W-1:0]                    w
    );
        logic [COL_W-1:0] res;
        if (v[15]) begin
            res = '0;
        end else if (v[14:0] > {2'b00, w}) begin
            res = w;
        end else begin
            res = v[COL_W-1:0];
        end
        return res;
    endfunction

    logic                 r_v1;
    logic                 r_row_ok;
    logic [COL_W-1:0]     r_xs;
    logic [COL_W-1:0]     r_xe;
    logic [COL_W-1:0]     r_xe_m1;
    logic [COL_W-1:0]     r_w;
    logic [2*COL_W-1:0]   r_rw;
    logic                 r_done;
    bsfe_pkg::t_span_plan r_plan;

    logic [COL_W-1:0]     n_xs;
    logic [COL_W-1:0]     n_xe;
    logic [POS_W-1:0]     end_pos;
    logic [POS_W-1:0]     start_pos;
    logic [POS_W-1:0]     last_pos;
    logic [OFF_W-1:0]     eo;

    assign n_xs = clamp_col(i_x_start, i_width);
    assign n_xe = clamp_col(i_x_end, i_width);

    // Stage one: clamp, row check, row base product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        if (i_start) begin
            r_xs     <= n_xs;
            r_xe     <= n_xe;
            r_xe_m1  <= n_xe - COL_W'(1);
            r_w      <= i_width;
            r_row_ok <= !i_row[15] && (i_row[14:0] < {2'b00, i_height});
            r_rw     <= i_row[COL_W-1:0] * i_width;
        end
    end

    // Stage two: bit positions, capacity check, word range and masks
    assign end_pos   = POS_W'(r_rw) + POS_W'(r_w);
    assign start_pos = POS_W'(r_rw) + POS_W'(r_xs);
    assign last_pos  = POS_W'(r_rw) + POS_W'(r_xe_m1);
    assign eo        = last_pos[OFF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v1;
        end
        if (r_v1) begin
            r_plan.ok      <= r_row_ok && (r_xs < r_xe) && !(end_pos > CAP);
            r_plan.sw      <= start_pos[POS_W-1:OFF_W];
            r_plan.ew      <= last_pos[POS_W-1:OFF_W];
            r_plan.lo_mask <= {WB{1'b1}} << start_pos[OFF_W-1:0];
            r_plan.hi_mask <= {WB{1'b1}} >> (OFF_W'(WB - 1) - eo);
        end
    end

    assign o_done = r_done;
    assign o_plan = r_plan;

endmodule

FILE: rtl/bitmask_span_fill_engine_core.sv
// ----------------------------------------------------------------------------
// bitmask_span_fill_engine_core
// Packed bitmap span-fill engine: span set/clear, word read, mask wipe.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one operation per beat (mode, row, x_start, x_end,
//   word_index); o_res returns exactly one beat per item (read_data,
//   span_applied). Mask width and height are written over the APB port at
//   byte addresses 0 and 4. The user must write them only while the engine
//   is idle; the block does not enforce it. Items are taken one at a time;
//   i_item.ready is high only when the sequencer is idle. A span goes from
//   acceptance to the result register through the span planner, then a
//   read-modify-write loop through the mask memory (separate read and
//   write ports) that reads one word per cycle while writing back the
//   previous one, then the last write-back and hand-off states. A word
//   read reads the memory, registers the word and hands it off. A mask
//   wipe sweeps the memory one word per cycle; after reset the same sweep
//   clears it, taking no item meanwhile (configuration writes are taken as ever).
//   The result sits in an output register; the next item is accepted while
//   it waits, and the engine holds a finished result until the slot frees
//   if the receiver stalls.
// ----------------------------------------------------------------------------
module bitmask_span_fill_engine_core #(
    parameter int MASK_WORDS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bsfe_in_if.sink                          i_item,
    bsfe_out_if.source                       o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bsfe_pkg::CFG_AW-1:0]      paddr,
    input  logic [bsfe_pkg::CFG_DW-1:0]      pwdata,
    output logic [bsfe_pkg::CFG_DW-1:0]      prdata,
    output logic                             pready
);

    localparam int AW    = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
    localparam int WB    = bsfe_pkg::WORD_BITS;
    localparam int COL_W = bsfe_pkg::COL_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(MASK_WORDS - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PLAN  = 8'b0000_0100,
        S_FILL  = 8'b0000_1000,
        S_LAST  = 8'b0001_0000,
        S_RDW   = 8'b0010_0000,
        S_RDX   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state               r_state;
    logic [COL_W-1:0]     r_width;
    logic [COL_W-1:0]     r_height;
    logic [AW-1:0]        r_k;
    logic [AW-1:0]        r_wk;
    logic [AW-1:0]        r_sw;
    logic [AW-1:0]        r_ew;
    logic [AW-1:0]        r_widx;
    logic                 r_rd_ok;
    logic                 r_pend;
    logic                 r_set;
    logic                 r_clr_reply;
    logic [WB-1:0]        r_rd_val;
    logic                 r_applied;
    logic                 r_out_valid;
    logic [WB-1:0]        r_out_data;
    logic                 r_out_applied;
    logic [WB-1:0]        r_mem [MASK_WORDS];
    logic [WB-1:0]        r_rdata;

    logic                 accept;
    logic                 span_start;
    logic                 cfg_wr;
    logic                 plan_done;
    bsfe_pkg::t_span_plan plan;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WB-1:0]        wr_data;
    logic [WB-1:0]        edit_mask;
    logic                 out_free;

    // Handshakes
    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign span_start   = accept && ((i_item.mode == bsfe_pkg::MODE_SET) ||
                                     (i_item.mode == bsfe_pkg::MODE_CLR));
    assign out_free     = !r_out_valid || o_res.ready;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == bsfe_pkg::REG_HEIGHT) ?
                    bsfe_pkg::CFG_DW'(r_height) : bsfe_pkg::CFG_DW'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bsfe_pkg::WIDTH_RST;
            r_height <= bsfe_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == bsfe_pkg::REG_WIDTH) begin
                r_width <= pwdata[COL_W-1:0];
            end else begin
                r_height <= pwdata[COL_W-1:0];
            end
        end
    end

    // Span planner
    bsfe_span_calc #(
        .MASK_WORDS (MASK_WORDS)
    ) u_span_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (span_start),
        .i_row     (i_item.row),
        .i_x_start (i_item.x_start),
        .i_x_end   (i_item.x_end),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_done    (plan_done),
        .o_plan    (plan)
    );

    // Memory port selection
    assign rd_en   = (r_state == S_FILL) || (r_state == S_RDW);
    assign rd_addr = (r_state == S_RDW) ? r_widx : r_k;

    always_comb begin
        edit_mask = {WB{1'b1}};
        if (r_wk == r_sw) begin
            edit_mask = edit_mask & plan.lo_mask;
        end
        if (r_wk == r_ew) begin
            edit_mask = edit_mask & plan.hi_mask;
        end
    end

    assign wr_en   = (r_state == S_CLEAR) || r_pend;
    assign wr_addr = (r_state == S_CLEAR) ? r_k : r_wk;
    assign wr_data = (r_state == S_CLEAR) ? '0 :
                     (r_set ? (r_rdata | edit_mask) : (r_rdata & ~edit_mask));

    // Mask memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_clr_reply <= 1'b0;
        end else begin
            r_pend <= (r_state == S_FILL);
            case (r_state)
                S_CLEAR: begin
                    if (r_k == LAST_WORD) begin
                        r_state <= r_clr_reply ? S_FIN : S_IDLE;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.mode)
                            bsfe_pkg::MODE_SET, bsfe_pkg::MODE_CLR: begin
                                r_state <= S_PLAN;
                            end
                            bsfe_pkg::MODE_READ: begin
                                r_state <= S_RDW;
                            end
                            bsfe_pkg::MODE_WIPE: begin
                                r_k         <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PLAN: begin
                    if (plan_done) begin
                        r_k     <= AW'(plan.sw);
                        r_state <= plan.ok ? S_FILL : S_FIN;
                    end
                end
                S_FILL: begin
                    if (r_k == r_ew) begin
                        r_state <= S_LAST;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_LAST: begin
                    r_state <= S_FIN;
                end
                S_RDW: begin
                    r_state <= S_RDX;
                end
                S_RDX: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item operands and result under construction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set     <= (i_item.mode == bsfe_pkg::MODE_SET);
            r_widx    <= AW'(i_item.word_index);
            r_rd_ok   <= (32'(i_item.word_index) < 32'(MASK_WORDS));
            r_rd_val  <= '0;
            r_applied <= 1'b0;
        end
        if (r_state == S_PLAN && plan_done) begin
            r_sw      <= AW'(plan.sw);
            r_ew      <= AW'(plan.ew);
            r_applied <= plan.ok;
        end
        if (r_state == S_FILL) begin
            r_wk <= r_k;
        end
        if (r_state == S_RDX) begin
            r_rd_val <= r_rd_ok ? r_rdata : '0;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_data    <= r_rd_val;
            r_out_applied <= r_applied;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.read_data    = r_out_data;
    assign o_res.span_applied = r_out_applied;

endmodule
